FILE: rtl/ps2kd_pkg.sv
// shared types, constants and key tables for the ps/2 scancode key decoder
package ps2kd_pkg;

  localparam int FIFO_DEPTH_DFLT = 256;
  localparam int KEY_W           = 10;

  // command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_SCAN   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SERIAL = 2'd2
  } cmd_t;

  // set-1 scancodes
  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [7:0] SC_RELEASE = 8'h80;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_SHIFT_L = 7'h2A;
  localparam logic [6:0] SC_SHIFT_R = 7'h36;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [6:0] SC_F1      = 7'h3B;
  localparam logic [6:0] SC_F8      = 7'h42;
  localparam logic [6:0] SC_F9      = 7'h43;
  localparam logic [6:0] SC_F10     = 7'h44;
  localparam logic [6:0] SC_F11     = 7'h57;
  localparam logic [6:0] SC_F12     = 7'h58;
  localparam logic [6:0] SC_MAP_END = 7'h3A;
  // extended (E0) scancodes
  localparam logic [6:0] SC_X_UP    = 7'h48;
  localparam logic [6:0] SC_X_DOWN  = 7'h50;
  localparam logic [6:0] SC_X_LEFT  = 7'h4B;
  localparam logic [6:0] SC_X_RIGHT = 7'h4D;
  localparam logic [6:0] SC_X_HOME  = 7'h47;
  localparam logic [6:0] SC_X_END   = 7'h4F;
  localparam logic [6:0] SC_X_PGUP  = 7'h49;
  localparam logic [6:0] SC_X_PGDN  = 7'h51;
  localparam logic [6:0] SC_X_INS   = 7'h52;
  localparam logic [6:0] SC_X_DEL   = 7'h53;
  localparam logic [6:0] SC_X_ENTER = 7'h1C;
  localparam logic [6:0] SC_X_SLASH = 7'h35;

  // key codes
  localparam logic [KEY_W-1:0] CODE_UP    = 10'h100;
  localparam logic [KEY_W-1:0] CODE_DOWN  = 10'h101;
  localparam logic [KEY_W-1:0] CODE_LEFT  = 10'h102;
  localparam logic [KEY_W-1:0] CODE_RIGHT = 10'h103;
  localparam logic [KEY_W-1:0] CODE_HOME  = 10'h104;
  localparam logic [KEY_W-1:0] CODE_END   = 10'h105;
  localparam logic [KEY_W-1:0] CODE_PGUP  = 10'h106;
  localparam logic [KEY_W-1:0] CODE_PGDN  = 10'h107;
  localparam logic [KEY_W-1:0] CODE_INS   = 10'h108;
  localparam logic [KEY_W-1:0] CODE_DEL   = 10'h109;
  localparam logic [KEY_W-1:0] CODE_F9    = 10'h10A;
  localparam logic [KEY_W-1:0] CODE_F10   = 10'h10B;
  localparam logic [KEY_W-1:0] CODE_F11   = 10'h10C;
  localparam logic [KEY_W-1:0] CODE_F12   = 10'h10D;
  localparam logic [KEY_W-1:0] CODE_LF    = 10'h00A;
  localparam logic [KEY_W-1:0] CODE_SLASH = 10'h02F;
  localparam logic [KEY_W-1:0] ALT_FLAG   = 10'h200;

  // serial byte rewrites
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_CASE_BIT = 8'h20;
  localparam logic [7:0] CH_CTRL_BASE = 8'h60;

  localparam logic signed [4:0] SCROLL_UP   = 5'sd10;
  localparam logic signed [4:0] SCROLL_DOWN = -5'sd10;
  localparam logic signed [3:0] FOCUS_F8    = -4'sd1;

  // us layout, indexed by scancode; entries past the last mapped key are zero
  localparam logic [7:0] MAP_PLAIN [64] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] MAP_SHIFTED [64] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // modifier and prefix flags
  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic prefix;
  } mods_t;

  // per-transaction result fields other than the key code
  typedef struct packed {
    logic              key_valid;
    logic              enqueued;
    logic              dropped;
    logic              serial_taken;
    logic              live_view;
    logic signed [4:0] scroll_lines;
    logic              focus_valid;
    logic signed [3:0] focus_target;
  } res_t;

  // decoder to fifo control
  typedef struct packed {
    logic             push;
    logic [KEY_W-1:0] push_code;
    logic             pop;
    mods_t            mods_nxt;
    res_t             res;
  } dec_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

FILE: rtl/ps2_scancode_key_decoder_unit.sv
// ps/2 set-1 scancode key decoder with key fifo: top level
// Takes one transaction per clock while the output is not stalled: a scancode byte,
// a serial byte or a key read, selected by in_tuser. Every input transaction yields
// exactly one output transaction, registered in the result stage and the output register.
// The decode (modifier flags, E0 prefix, us table lookup) is combinational logic;
// keys are held in a FIFO_DEPTH-entry synchronous ram with one write and one
// registered read port, so a read pops the entry at the read pointer in the
// accept cycle and the key appears from the ram output register in the next cycle.
// The fifo holds at most FIFO_DEPTH-1 keys. A result stage plus an output
// register let a new input be accepted while a finished result waits on out_tready;
// with out_tready high the sustained rate is one transaction per cycle. The key ram has
// no reset and needs no clearing pass: entries are only read after being written.
module ps2_scancode_key_decoder_unit #(
  parameter int FIFO_DEPTH = ps2kd_pkg::FIFO_DEPTH_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] key_code, [10] enqueued, [11] dropped,
                                  // [12] serial_taken, [13] live_view,
                                  // [18:14] scroll_lines, [22:19] focus_target, [23] zero
  output logic [1:0]  out_tuser   // [0] key_valid, [1] focus_valid
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  // modifier state
  ps2kd_pkg::mods_t mods_r;
  ps2kd_pkg::dec_t  dec;

  // fifo pointers
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             fifo_full;
  logic             fifo_empty;
  logic [ps2kd_pkg::KEY_W-1:0] ram_rdata;

  // handshake
  logic in_fire;
  logic out_load;

  // result stage (waits on the ram read) and output register
  logic                          s1_valid_r, s1_valid_nxt;
  ps2kd_pkg::res_t               s1_res_r;
  logic                          out_valid_r, out_valid_nxt;
  ps2kd_pkg::res_t               out_res_r;
  logic [ps2kd_pkg::KEY_W-1:0]   out_code_r;

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  ps2kd_decode u_decode (
    .cmd        (in_tuser),
    .data_byte  (in_tdata),
    .mods       (mods_r),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty),
    .dec        (dec)
  );

  ps2kd_ptrs #(
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ptrs (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_fire && dec.push),
    .pop    (in_fire && dec.pop),
    .wr_ptr (wr_ptr),
    .rd_ptr (rd_ptr),
    .full   (fifo_full),
    .empty  (fifo_empty)
  );

  // read of a just-written entry comes in a later cycle, so no bypass
  ps2kd_key_ram #(
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (PTR_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (in_fire && dec.push),
    .waddr (wr_ptr),
    .wdata (dec.push_code),
    .re    (in_fire && dec.pop),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mods_r <= dec.mods_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload; ram output holds while the result stage is occupied
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res_r <= dec.res;
    end
    if (out_load) begin
      out_res_r  <= s1_res_r;
      out_code_r <= s1_res_r.key_valid ? ram_rdata : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.focus_valid, out_res_r.key_valid};
  assign out_tdata  = {1'b0,
                       out_res_r.focus_target,
                       out_res_r.scroll_lines,
                       out_res_r.live_view,
                       out_res_r.serial_taken,
                       out_res_r.dropped,
                       out_res_r.enqueued,
                       out_code_r};

endmodule

FILE: rtl/ps2kd_key_ram.sv
// key fifo storage: one write port, one registered read port
module ps2kd_key_ram #(
  parameter int DEPTH  = ps2kd_pkg::FIFO_DEPTH_DFLT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [ps2kd_pkg::KEY_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [ps2kd_pkg::KEY_W-1:0] rdata
);

  logic [ps2kd_pkg::KEY_W-1:0] mem [DEPTH];
  logic [ps2kd_pkg::KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ps2kd_decode.sv
// scancode, serial and read decode: next flags, fifo push/pop and result fields
module ps2kd_decode (
  input  logic [1:0]        cmd,
  input  logic [7:0]        data_byte,
  input  ps2kd_pkg::mods_t  mods,
  input  logic              fifo_full,
  input  logic              fifo_empty,
  output ps2kd_pkg::dec_t   dec
);

  logic                         want;
  logic [ps2kd_pkg::KEY_W-1:0]  qcode;
  logic                         rel;
  logic                         ext;
  logic [6:0]                   sc;
  logic [7:0]                   ch;
  logic [7:0]                   ser;
  logic                         up;

  assign rel = (data_byte & ps2kd_pkg::SC_RELEASE) != 8'h00;
  assign sc  = data_byte[6:0];
  assign ext = mods.prefix;

  // table lookup with shift / caps lock
  always_comb begin
    up = ps2kd_pkg::is_alpha(ps2kd_pkg::MAP_PLAIN[sc[5:0]]) ? (mods.shift ^ mods.caps)
                                                             : mods.shift;
    ch = up ? ps2kd_pkg::MAP_SHIFTED[sc[5:0]] : ps2kd_pkg::MAP_PLAIN[sc[5:0]];
  end

  always_comb begin
    ser = data_byte;
    if (data_byte == ps2kd_pkg::CH_CR) begin
      ser = ps2kd_pkg::CH_LF;
    end else if (data_byte == ps2kd_pkg::CH_DEL) begin
      ser = ps2kd_pkg::CH_BS;
    end
  end

  always_comb begin
    dec          = '0;
    dec.mods_nxt = mods;
    want         = 1'b0;
    qcode        = '0;
    unique case (cmd)
      ps2kd_pkg::CMD_READ: begin
        if (!fifo_empty) begin
          dec.res.key_valid = 1'b1;
          dec.pop           = 1'b1;
        end
      end
      ps2kd_pkg::CMD_SERIAL: begin
        if (!fifo_full) begin
          dec.res.serial_taken = 1'b1;
          want                 = 1'b1;
          qcode                = {2'b00, ser};
        end
      end
      ps2kd_pkg::CMD_SCAN: begin
        if (data_byte == ps2kd_pkg::SC_PREFIX) begin
          dec.mods_nxt.prefix = 1'b1;
        end else begin
          dec.mods_nxt.prefix = 1'b0;
          if (sc == ps2kd_pkg::SC_SHIFT_L || sc == ps2kd_pkg::SC_SHIFT_R) begin
            dec.mods_nxt.shift = !rel;
          end else if (sc == ps2kd_pkg::SC_CTRL) begin
            dec.mods_nxt.ctrl = !rel;
          end else if (sc == ps2kd_pkg::SC_ALT) begin
            dec.mods_nxt.alt = !rel;
          end else if (rel) begin
            // other releases are ignored
          end else if (sc == ps2kd_pkg::SC_CAPS && !ext) begin
            dec.mods_nxt.caps = !mods.caps;
          end else if (ext) begin
            case (sc)
              ps2kd_pkg::SC_X_UP:    begin want = 1'b1; qcode = ps2kd_pkg::CODE_UP;    end
              ps2kd_pkg::SC_X_DOWN:  begin want = 1'b1; qcode = ps2kd_pkg::CODE_DOWN;  end
              ps2kd_pkg::SC_X_LEFT:  begin want = 1'b1; qcode = ps2kd_pkg::CODE_LEFT;  end
              ps2kd_pkg::SC_X_RIGHT: begin want = 1'b1; qcode = ps2kd_pkg::CODE_RIGHT; end
              ps2kd_pkg::SC_X_HOME:  begin want = 1'b1; qcode = ps2kd_pkg::CODE_HOME;  end
              ps2kd_pkg::SC_X_END:   begin want = 1'b1; qcode = ps2kd_pkg::CODE_END;   end
              ps2kd_pkg::SC_X_PGUP: begin
                if (mods.shift) begin
                  dec.res.scroll_lines = ps2kd_pkg::SCROLL_UP;
                end else begin
                  want  = 1'b1;
                  qcode = ps2kd_pkg::CODE_PGUP;
                end
              end
              ps2kd_pkg::SC_X_PGDN: begin
                if (mods.shift) begin
                  dec.res.scroll_lines = ps2kd_pkg::SCROLL_DOWN;
                end else begin
                  want  = 1'b1;
                  qcode = ps2kd_pkg::CODE_PGDN;
                end
              end
              ps2kd_pkg::SC_X_INS:   begin want = 1'b1; qcode = ps2kd_pkg::CODE_INS;   end
              ps2kd_pkg::SC_X_DEL:   begin want = 1'b1; qcode = ps2kd_pkg::CODE_DEL;   end
              ps2kd_pkg::SC_X_ENTER: begin want = 1'b1; qcode = ps2kd_pkg::CODE_LF;    end
              ps2kd_pkg::SC_X_SLASH: begin want = 1'b1; qcode = ps2kd_pkg::CODE_SLASH; end
              default: ;
            endcase
          end else if (sc >= ps2kd_pkg::SC_F1 && sc <= ps2kd_pkg::SC_F8) begin
            dec.res.focus_valid  = 1'b1;
            dec.res.focus_target = (sc == ps2kd_pkg::SC_F8) ? ps2kd_pkg::FOCUS_F8
                                                            : 4'(sc - ps2kd_pkg::SC_F1);
          end else if (sc == ps2kd_pkg::SC_F9) begin
            want  = 1'b1;
            qcode = ps2kd_pkg::CODE_F9;
          end else if (sc == ps2kd_pkg::SC_F10) begin
            want  = 1'b1;
            qcode = ps2kd_pkg::CODE_F10;
          end else if (sc == ps2kd_pkg::SC_F11) begin
            want  = 1'b1;
            qcode = ps2kd_pkg::CODE_F11;
          end else if (sc == ps2kd_pkg::SC_F12) begin
            want  = 1'b1;
            qcode = ps2kd_pkg::CODE_F12;
          end else if (sc < ps2kd_pkg::SC_MAP_END) begin
            if (ch != 8'h00) begin
              want = 1'b1;
              if (mods.ctrl && ps2kd_pkg::is_alpha(ch)) begin
                // ctrl+letter gives 1..26
                qcode = {2'b00, (ch | ps2kd_pkg::CH_CASE_BIT) - ps2kd_pkg::CH_CTRL_BASE};
              end else if (mods.alt) begin
                qcode = ps2kd_pkg::ALT_FLAG | {2'b00, ch};
              end else begin
                qcode = {2'b00, ch};
              end
            end
          end
        end
      end
      default: ;
    endcase

    // any queue attempt raises live view; full fifo drops the key
    if (want) begin
      dec.res.live_view = 1'b1;
      if (fifo_full) begin
        dec.res.dropped = 1'b1;
      end else begin
        dec.push         = 1'b1;
        dec.push_code    = qcode;
        dec.res.enqueued = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ps2kd_top_unused_placeholder.sv
// ring pointer arithmetic for the key fifo: wrap-around increment and full/empty flags
module ps2kd_ptrs #(
  parameter int DEPTH  = ps2kd_pkg::FIFO_DEPTH_DFLT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              pop,
  output logic [ADDR_W-1:0] wr_ptr,
  output logic [ADDR_W-1:0] rd_ptr,
  output logic              full,
  output logic              empty
);

  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0] wr_inc;
  logic [ADDR_W-1:0] rd_inc;

  assign wr_inc = (wr_ptr_r == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign wr_ptr_nxt = push ? wr_inc : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_inc : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // one slot stays empty
  assign full   = (wr_inc == rd_ptr_r);
  assign empty  = (wr_ptr_r == rd_ptr_r);
  assign wr_ptr = wr_ptr_r;
  assign rd_ptr = rd_ptr_r;

endmodule

FILE: test/tb_ps2_scancode_key_decoder_unit.sv
// self-checking testbench for the ps/2 scancode key decoder with key fifo
`timescale 1ns / 100ps

module tb_ps2_scancode_key_decoder_unit;
  import ps2kd_pkg::*;

  // no-op command, outside the package enum
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int KEY_SLOTS = FIFO_DEPTH_DFLT;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // results pass the result stage and the output register; leave slack at the end
  localparam int TAIL_CYCLES = 10;

  // us layout, indexed by scancode 0x00..0x39
  localparam logic [7:0] LOWER_MAP [58] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };
  localparam logic [7:0] UPPER_MAP [58] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // e0-prefixed keys that decode to something
  localparam logic [6:0] EXT_KEYS [12] = '{
    SC_X_UP, SC_X_DOWN, SC_X_LEFT, SC_X_RIGHT, SC_X_HOME, SC_X_END,
    SC_X_PGUP, SC_X_PGDN, SC_X_INS, SC_X_DEL, SC_X_ENTER, SC_X_SLASH
  };

  // one result transaction, all fields as plain bit vectors
  typedef struct packed {
    logic       key_valid;
    logic [9:0] key_code;
    logic       enqueued;
    logic       dropped;
    logic       serial_taken;
    logic       live_view;
    logic [4:0] scroll_lines;
    logic       focus_valid;
    logic [3:0] focus_target;
  } key_report_t;

  // keeps its own copy of the decoder state and the reports still due
  class keystroke_scoreboard;
    logic [9:0]  key_ring [KEY_SLOTS];
    int unsigned wr_idx, rd_idx;
    bit          shift_dn, ctrl_dn, alt_dn, caps_on, e0_seen;
    key_report_t cur;
    key_report_t pending_reports [$];
    int unsigned errors;

    function new();
      wr_idx = 0;
      rd_idx = 0;
      shift_dn = 0;
      ctrl_dn = 0;
      alt_dn = 0;
      caps_on = 0;
      e0_seen = 0;
      errors = 0;
    endfunction

    function int unsigned stored();
      return (wr_idx + KEY_SLOTS - rd_idx) % KEY_SLOTS;
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction

    function bit ring_full();
      return ((wr_idx + 1) % KEY_SLOTS) == rd_idx;
    endfunction

    function bit alpha_char(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    // every queue attempt asks for the live view, even when the key is lost
    function void push_key(input logic [9:0] code);
      cur.live_view = 1'b1;
      if (ring_full()) begin
        cur.dropped = 1'b1;
      end else begin
        key_ring[wr_idx] = code;
        wr_idx = (wr_idx + 1) % KEY_SLOTS;
        cur.enqueued = 1'b1;
      end
    endfunction

    // decode one accepted input transaction and queue the report it causes
    function void accept_byte(input logic [1:0] cmd, input logic [7:0] data);
      logic [6:0] sc;
      logic [7:0] ch;
      logic       ext, rel, upper;
      cur = '0;
      sc = data[6:0];
      rel = data[7];
      if (cmd == CMD_READ) begin
        if (wr_idx != rd_idx) begin
          cur.key_valid = 1'b1;
          cur.key_code = key_ring[rd_idx];
          rd_idx = (rd_idx + 1) % KEY_SLOTS;
        end
      end else if (cmd == CMD_SERIAL) begin
        if (!ring_full()) begin
          cur.serial_taken = 1'b1;
          ch = data;
          if (ch == CH_CR) ch = CH_LF;
          if (ch == CH_DEL) ch = CH_BS;
          push_key(10'(ch));
        end
      end else if (cmd == CMD_SCAN) begin
        if (data == SC_PREFIX) begin
          e0_seen = 1'b1;
        end else begin
          ext = e0_seen;
          e0_seen = 1'b0;
          if (sc == SC_SHIFT_L || sc == SC_SHIFT_R) begin
            shift_dn = !rel;
          end else if (sc == SC_CTRL) begin
            ctrl_dn = !rel;
          end else if (sc == SC_ALT) begin
            alt_dn = !rel;
          end else if (!rel && ext) begin
            case (sc)
              SC_X_UP:    push_key(CODE_UP);
              SC_X_DOWN:  push_key(CODE_DOWN);
              SC_X_LEFT:  push_key(CODE_LEFT);
              SC_X_RIGHT: push_key(CODE_RIGHT);
              SC_X_HOME:  push_key(CODE_HOME);
              SC_X_END:   push_key(CODE_END);
              SC_X_PGUP: begin
                if (shift_dn) cur.scroll_lines = SCROLL_UP;
                else push_key(CODE_PGUP);
              end
              SC_X_PGDN: begin
                if (shift_dn) cur.scroll_lines = SCROLL_DOWN;
                else push_key(CODE_PGDN);
              end
              SC_X_INS:   push_key(CODE_INS);
              SC_X_DEL:   push_key(CODE_DEL);
              SC_X_ENTER: push_key(CODE_LF);
              SC_X_SLASH: push_key(CODE_SLASH);
              default: ;
            endcase
          end else if (!rel) begin
            if (sc == SC_CAPS) begin
              caps_on = !caps_on;
            end else if (sc >= SC_F1 && sc <= SC_F8) begin
              cur.focus_valid = 1'b1;
              cur.focus_target = (sc == SC_F8) ? FOCUS_F8 : 4'(sc - SC_F1);
            end else if (sc == SC_F9) begin
              push_key(CODE_F9);
            end else if (sc == SC_F10) begin
              push_key(CODE_F10);
            end else if (sc == SC_F11) begin
              push_key(CODE_F11);
            end else if (sc == SC_F12) begin
              push_key(CODE_F12);
            end else if (sc < SC_MAP_END) begin
              // caps lock only flips letters
              upper = alpha_char(LOWER_MAP[sc]) ? (shift_dn ^ caps_on) : shift_dn;
              ch = upper ? UPPER_MAP[sc] : LOWER_MAP[sc];
              if (ch != 8'h00) begin
                if (ctrl_dn && alpha_char(ch)) push_key(10'((ch | CH_CASE_BIT) - CH_CTRL_BASE));
                else if (alt_dn) push_key(ALT_FLAG | 10'(ch));
                else push_key(10'(ch));
              end
            end
          end
        end
      end
      pending_reports.push_back(cur);
    endfunction

    function void match_field(input string name, input logic [9:0] want,
                              input logic [9:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(input logic [23:0] tdata, input logic [1:0] tuser);
      key_report_t want;
      if (pending_reports.size() == 0) begin
        $error("result transaction with nothing due: tdata %h tuser %h", tdata, tuser);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      match_field("key_valid", 10'(want.key_valid), 10'(tuser[0]));
      match_field("key_code", want.key_code, tdata[9:0]);
      match_field("enqueued", 10'(want.enqueued), 10'(tdata[10]));
      match_field("dropped", 10'(want.dropped), 10'(tdata[11]));
      match_field("serial_taken", 10'(want.serial_taken), 10'(tdata[12]));
      match_field("live_view", 10'(want.live_view), 10'(tdata[13]));
      match_field("scroll_lines", 10'(want.scroll_lines), 10'(tdata[18:14]));
      match_field("focus_valid", 10'(want.focus_valid), 10'(tuser[1]));
      match_field("focus_target", 10'(want.focus_target), 10'(tdata[22:19]));
      match_field("tdata_pad", 10'd0, 10'(tdata[23]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = CMD_SCAN;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  keystroke_scoreboard sb = new();

  // idle knobs for sender and receiver, plus run bookkeeping
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int          sink_gap = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  ps2_scancode_key_decoder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: tready drops now and then while idling is on
  always @(negedge clk) begin
    if (sink_idle_en && sink_gap > 0) begin
      out_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // every accepted result transaction is checked against the oldest report due
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata, out_tuser);
  end

  // drive one input transaction; called and returns at a falling edge
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    sb.accept_byte(cmd, data);
    if (cmd != CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  // make or break code, with the e0 prefix for extended keys
  task automatic key_byte(input logic [6:0] sc, input logic ext, input logic rel);
    if (ext) send_item(CMD_SCAN, SC_PREFIX);
    send_item(CMD_SCAN, {rel, sc});
  endtask

  // a well-formed keystroke: optional modifiers held around one key
  task automatic type_key();
    logic [6:0] mod_sc [3];
    logic       mod_on [3];
    logic       mod_ext [3];
    logic [6:0] sc;
    logic       ext;
    int         pick;
    mod_sc[0] = $urandom_range(0, 1) ? SC_SHIFT_L : SC_SHIFT_R;
    mod_sc[1] = SC_CTRL;
    mod_sc[2] = SC_ALT;
    for (int i = 0; i < 3; i++) begin
      mod_on[i] = ($urandom_range(0, 3) == 0);
      mod_ext[i] = ($urandom_range(0, 3) == 0);
      if (mod_on[i]) key_byte(mod_sc[i], mod_ext[i], 1'b0);
    end
    pick = $urandom_range(0, 99);
    ext = (pick < 20);
    if (pick < 15) sc = EXT_KEYS[$urandom_range(0, 11)];
    else if (pick < 20) sc = 7'($urandom_range(0, 127));
    else if (pick < 26) sc = SC_CAPS;
    else if (pick < 36) sc = 7'($urandom_range(SC_F1, SC_F8));
    else if (pick < 40) begin
      case ($urandom_range(0, 3))
        0: sc = SC_F9;
        1: sc = SC_F10;
        2: sc = SC_F11;
        default: sc = SC_F12;
      endcase
    end else if (pick < 46) sc = 7'($urandom_range(SC_MAP_END, 127));
    else sc = 7'($urandom_range(0, SC_MAP_END - 1));
    key_byte(sc, ext, 1'b0);
    if ($urandom_range(0, 3) != 0) key_byte(sc, ext, 1'b1);
    // now and then a modifier stays held into the next keystroke
    for (int i = 0; i < 3; i++) begin
      if (mod_on[i] && $urandom_range(0, 7) != 0) key_byte(mod_sc[i], mod_ext[i], 1'b1);
    end
  endtask

  // one random step: key read, serial byte, raw noise or a keystroke
  task automatic random_action(input int read_pct);
    int         roll;
    logic [7:0] b;
    roll = $urandom_range(0, 99);
    if (roll < read_pct) begin
      send_item(CMD_READ, 8'($urandom));
    end else if (roll < read_pct + 25) begin
      case ($urandom_range(0, 5))
        0: b = CH_CR;
        1: b = CH_DEL;
        default: b = 8'($urandom);
      endcase
      send_item(CMD_SERIAL, b);
    end else if (roll < read_pct + 33) begin
      send_item(2'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      type_key();
    end
  endtask

  // hold the sender until every report due has come back
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [9:0]  directed [$];
    int unsigned actions;
    int unsigned at_full;
    int unsigned waited;

    // directed part: empty read, no-op command, serial rewrites, caps and shift,
    // shifted page keys, arrow up, extended ctrl, ctrl letter, alt letter,
    // focus keys, f9 and f12, zero table entry, unmapped code, extended caps
    directed = '{
      {CMD_READ, 8'hFF},   {CMD_NONE, 8'hFF},   {CMD_SERIAL, CH_CR},
      {CMD_SERIAL, CH_DEL}, {CMD_SERIAL, 8'h00}, {CMD_SERIAL, 8'hFF},
      {CMD_SCAN, 8'h1E},   {CMD_SCAN, 8'h3A},   {CMD_SCAN, 8'h1E},
      {CMD_SCAN, 8'h2A},   {CMD_SCAN, 8'h1E},   {CMD_SCAN, 8'h03},
      {CMD_SCAN, SC_PREFIX}, {CMD_SCAN, 8'h49}, {CMD_SCAN, SC_PREFIX},
      {CMD_SCAN, 8'h51},   {CMD_SCAN, 8'hAA},   {CMD_SCAN, SC_PREFIX},
      {CMD_SCAN, 8'h48},   {CMD_SCAN, SC_PREFIX}, {CMD_SCAN, 8'h1D},
      {CMD_SCAN, 8'h2E},   {CMD_SCAN, SC_PREFIX}, {CMD_SCAN, 8'h9D},
      {CMD_SCAN, 8'h38},   {CMD_SCAN, 8'h10},   {CMD_SCAN, 8'hB8},
      {CMD_SCAN, 8'h3B},   {CMD_SCAN, 8'h42},   {CMD_SCAN, 8'h43},
      {CMD_SCAN, 8'h58},   {CMD_SCAN, 8'h00},   {CMD_SCAN, 8'h7F},
      {CMD_SCAN, SC_PREFIX}, {CMD_SCAN, 8'h3A}, {CMD_READ, 8'h00},
      {CMD_READ, 8'h5A}
    };

    // hold synchronous reset, then release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_item(directed[i][9:8], directed[i][7:0]);

    // fill phase: few reads, so the fifo fills up and keys and serial bytes get refused
    at_full = 0;
    while (at_full < 40 && items_sent < 800) begin
      random_action(3);
      if (sb.stored() == KEY_SLOTS - 1) at_full++;
    end

    // sender holds off until the block has caught up
    drain_reports();

    // drain-heavy phase, idling switched on and off in stretches
    actions = 0;
    while (items_sent < 1150) begin
      if (actions % 40 == 0) begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      random_action(45);
      actions++;
    end

    // last part: back to back, no idling on either side
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    while (items_sent < 1450) random_action(25);

    in_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
